// File: rtl/msbr_pkg.sv
// Shared types and constants for the card single-block read sequencer.
package msbr_pkg;

   localparam int BLOCK_BYTES = 512;
   localparam logic [31:0] START_BASE = 32'h0000_0000;

   localparam logic [7:0] CMD_READ_BLOCK = 8'h51;
   localparam logic [7:0] IDLE_BYTE = 8'hFF;
   localparam logic [7:0] START_TOKEN = 8'hFE;
   localparam logic [7:0] R1_READY = 8'h00;
   localparam logic [7:0] R1_IDLE = 8'h01;
   localparam logic [11:0] TRAILER_BYTES = 12'd3;

   localparam logic [7:0] RESPONSE_TRIES_RESET = 8'd33;
   localparam logic [9:0] TOKEN_TRIES_RESET = 10'd256;
   localparam logic [11:0] RELEASE_TRIES_RESET = 12'd1024;

   typedef enum logic [1:0] {
      KIND_READ_ADDR = 2'd0,
      KIND_READ_BASE = 2'd1,
      KIND_SET_BASE  = 2'd2,
      KIND_RX_BYTE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_RESPONSE_TRIES = 2'd0,
      CSR_TOKEN_TRIES    = 2'd1,
      CSR_RELEASE_TRIES  = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_IDX_ADDR3 = 3'd1,
      CMD_IDX_ADDR2 = 3'd2,
      CMD_IDX_ADDR1 = 3'd3,
      CMD_IDX_ADDR0 = 3'd4,
      CMD_IDX_CRC   = 3'd5
   } cmd_index_type;

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_CMD     = 7'b0000010,
      PH_RESP    = 7'b0000100,
      PH_TOKEN   = 7'b0001000,
      PH_DATA    = 7'b0010000,
      PH_TRAIL   = 7'b0100000,
      PH_RELEASE = 7'b1000000
   } phase_type;

endpackage

// File: rtl/mmc_spi_block_read.sv
// Top level of the card single-block read sequencer in SPI mode.
// Every accepted item (read request, base update or received byte) produces exactly one
// result item, which is held in a single output register and appears on the rsp_ channel
// in the cycle after acceptance. A new item is accepted in every cycle unless that output
// register holds a result that is stalled, so the sustained rate is one item per clock.
// A read issues command 0x51, four address bytes and a check byte, polls for the R1
// response, waits for the start token, streams the block bytes out with their index,
// sends three trailer bytes and waits for the card to release before deselecting.
// Configuration registers may be written only while no read is in progress.
module mmc_spi_block_read (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_address,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_send,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_select,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_data_byte,
   output logic [8:0]  rsp_data_index,
   output logic        rsp_done_res,
   output logic        rsp_success,
   output logic [7:0]  rsp_response_code,
   output logic        rsp_rejected,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   logic [7:0]  response_tries_ff;
   logic [9:0]  token_tries_ff;
   logic [11:0] release_tries_ff;

   msbr_pkg::phase_type phase_ff, phase_in;
   logic [11:0] try_count_ff, try_count_in;
   logic [2:0]  cmd_index_ff, cmd_index_in;
   logic [31:0] read_address_ff, read_address_in;
   logic [31:0] base_ff, base_in;
   logic        token_seen_ff, token_seen_in;
   logic [7:0]  last_response_ff, last_response_in;
   logic [8:0]  data_count_ff, data_count_in;

   logic        rsp_valid_ff;
   logic        send_ff, send_in;
   logic [7:0]  tx_byte_ff, tx_byte_in;
   logic        select_ff;
   logic        data_valid_ff, data_valid_in;
   logic [7:0]  data_byte_ff, data_byte_in;
   logic [8:0]  data_index_ff, data_index_in;
   logic        done_ff, done_in;
   logic        success_ff, success_in;
   logic [7:0]  response_code_ff;
   logic        rejected_ff, rejected_in;

   logic        accept;
   logic        busy;
   logic [11:0] response_limit;
   logic [11:0] token_limit;
   logic [11:0] release_limit;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;
   assign busy = (phase_ff != msbr_pkg::PH_IDLE);

   assign response_limit = (response_tries_ff == 8'd0) ? 12'd1 : {4'd0, response_tries_ff};
   assign token_limit = (token_tries_ff == 10'd0) ? 12'd1 : {2'd0, token_tries_ff};
   assign release_limit = (release_tries_ff == 12'd0) ? 12'd1 : release_tries_ff;

   always_comb begin
      phase_in = phase_ff;
      try_count_in = try_count_ff;
      cmd_index_in = cmd_index_ff;
      read_address_in = read_address_ff;
      base_in = base_ff;
      token_seen_in = token_seen_ff;
      last_response_in = last_response_ff;
      data_count_in = data_count_ff;
      send_in = 1'b0;
      tx_byte_in = 8'd0;
      data_valid_in = 1'b0;
      data_byte_in = 8'd0;
      data_index_in = 9'd0;
      done_in = 1'b0;
      success_in = 1'b0;
      rejected_in = 1'b0;

      case (msbr_pkg::kind_type'(req_kind)) inside
         msbr_pkg::KIND_SET_BASE: begin
            base_in = req_address;
         end
         msbr_pkg::KIND_READ_ADDR, msbr_pkg::KIND_READ_BASE: begin
            if (busy) begin
               rejected_in = 1'b1;
            end else begin
               if (req_kind == msbr_pkg::KIND_READ_ADDR) begin
                  read_address_in = req_address;
               end else begin
                  read_address_in = base_ff;
                  base_in = base_ff + 32'(msbr_pkg::BLOCK_BYTES);
               end
               phase_in = msbr_pkg::PH_CMD;
               cmd_index_in = 3'd0;
               token_seen_in = 1'b0;
               last_response_in = msbr_pkg::IDLE_BYTE;
               data_count_in = 9'd0;
               try_count_in = 12'd0;
               send_in = 1'b1;
               tx_byte_in = msbr_pkg::CMD_READ_BLOCK;
            end
         end
         default: begin
            if (!busy) begin
               rejected_in = 1'b1;
            end else begin
               unique case (phase_ff)
                  msbr_pkg::PH_CMD: begin
                     cmd_index_in = cmd_index_ff + 3'd1;
                     send_in = 1'b1;
                     tx_byte_in = msbr_pkg::IDLE_BYTE;
                     unique case (cmd_index_in)
                        msbr_pkg::CMD_IDX_ADDR3: tx_byte_in = read_address_ff[31:24];
                        msbr_pkg::CMD_IDX_ADDR2: tx_byte_in = read_address_ff[23:16];
                        msbr_pkg::CMD_IDX_ADDR1: tx_byte_in = read_address_ff[15:8];
                        msbr_pkg::CMD_IDX_ADDR0: tx_byte_in = read_address_ff[7:0];
                        msbr_pkg::CMD_IDX_CRC:   tx_byte_in = msbr_pkg::IDLE_BYTE;
                        default: begin
                           phase_in = msbr_pkg::PH_RESP;
                           try_count_in = 12'd1;
                        end
                     endcase
                  end
                  msbr_pkg::PH_RESP: begin
                     last_response_in = req_rx_byte;
                     send_in = 1'b1;
                     tx_byte_in = msbr_pkg::IDLE_BYTE;
                     if (req_rx_byte == msbr_pkg::R1_READY) begin
                        phase_in = msbr_pkg::PH_TOKEN;
                        try_count_in = 12'd1;
                     end else if (req_rx_byte != msbr_pkg::R1_IDLE
                                  && try_count_ff < response_limit) begin
                        try_count_in = try_count_ff + 12'd1;
                     end else begin
                        phase_in = msbr_pkg::PH_TRAIL;
                        try_count_in = 12'd1;
                     end
                  end
                  msbr_pkg::PH_TOKEN: begin
                     send_in = 1'b1;
                     tx_byte_in = msbr_pkg::IDLE_BYTE;
                     if (req_rx_byte == msbr_pkg::START_TOKEN) begin
                        token_seen_in = 1'b1;
                        phase_in = msbr_pkg::PH_DATA;
                        data_count_in = 9'd0;
                     end else if (try_count_ff < token_limit) begin
                        try_count_in = try_count_ff + 12'd1;
                     end else begin
                        phase_in = msbr_pkg::PH_TRAIL;
                        try_count_in = 12'd1;
                     end
                  end
                  msbr_pkg::PH_DATA: begin
                     data_valid_in = 1'b1;
                     data_byte_in = req_rx_byte;
                     data_index_in = data_count_ff;
                     send_in = 1'b1;
                     tx_byte_in = msbr_pkg::IDLE_BYTE;
                     if (data_count_ff == 9'(msbr_pkg::BLOCK_BYTES - 1)) begin
                        phase_in = msbr_pkg::PH_TRAIL;
                        try_count_in = 12'd1;
                     end else begin
                        data_count_in = data_count_ff + 9'd1;
                     end
                  end
                  msbr_pkg::PH_TRAIL: begin
                     send_in = 1'b1;
                     tx_byte_in = msbr_pkg::IDLE_BYTE;
                     if (try_count_ff < msbr_pkg::TRAILER_BYTES) begin
                        try_count_in = try_count_ff + 12'd1;
                     end else begin
                        phase_in = msbr_pkg::PH_RELEASE;
                        try_count_in = 12'd1;
                     end
                  end
                  msbr_pkg::PH_RELEASE: begin
                     if (req_rx_byte != 8'd0 || try_count_ff >= release_limit) begin
                        phase_in = msbr_pkg::PH_IDLE;
                        try_count_in = 12'd0;
                        done_in = 1'b1;
                        success_in = token_seen_ff;
                     end else begin
                        try_count_in = try_count_ff + 12'd1;
                        send_in = 1'b1;
                        tx_byte_in = msbr_pkg::IDLE_BYTE;
                     end
                  end
                  default: begin
                     phase_in = msbr_pkg::PH_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         response_tries_ff <= msbr_pkg::RESPONSE_TRIES_RESET;
         token_tries_ff <= msbr_pkg::TOKEN_TRIES_RESET;
         release_tries_ff <= msbr_pkg::RELEASE_TRIES_RESET;
      end else if (csr_write) begin
         unique case (msbr_pkg::csr_index_type'(csr_index))
            msbr_pkg::CSR_RESPONSE_TRIES: response_tries_ff <= csr_data[7:0];
            msbr_pkg::CSR_TOKEN_TRIES:    token_tries_ff <= csr_data[9:0];
            msbr_pkg::CSR_RELEASE_TRIES:  release_tries_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= msbr_pkg::PH_IDLE;
         try_count_ff <= 12'd0;
         cmd_index_ff <= 3'd0;
         read_address_ff <= 32'd0;
         base_ff <= msbr_pkg::START_BASE;
         token_seen_ff <= 1'b0;
         last_response_ff <= msbr_pkg::IDLE_BYTE;
         data_count_ff <= 9'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         try_count_ff <= try_count_in;
         cmd_index_ff <= cmd_index_in;
         read_address_ff <= read_address_in;
         base_ff <= base_in;
         token_seen_ff <= token_seen_in;
         last_response_ff <= last_response_in;
         data_count_ff <= data_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         send_ff <= send_in;
         tx_byte_ff <= tx_byte_in;
         select_ff <= (phase_in != msbr_pkg::PH_IDLE);
         data_valid_ff <= data_valid_in;
         data_byte_ff <= data_byte_in;
         data_index_ff <= data_index_in;
         done_ff <= done_in;
         success_ff <= success_in;
         response_code_ff <= last_response_in;
         rejected_ff <= rejected_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_send = send_ff;
   assign rsp_tx_byte = tx_byte_ff;
   assign rsp_select = select_ff;
   assign rsp_data_valid = data_valid_ff;
   assign rsp_data_byte = data_byte_ff;
   assign rsp_data_index = data_index_ff;
   assign rsp_done_res = done_ff;
   assign rsp_success = success_ff;
   assign rsp_response_code = response_code_ff;
   assign rsp_rejected = rejected_ff;

endmodule

// File: rtl/msbr_checker.sv
// Port-level assertions for the block read sequencer and their binding to the top level.
module msbr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_send,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_select,
   input logic        rsp_data_valid,
   input logic [7:0]  rsp_data_byte,
   input logic [8:0]  rsp_data_index,
   input logic        rsp_done_res,
   input logic        rsp_success,
   input logic [7:0]  rsp_response_code,
   input logic        rsp_rejected
);

   // A stalled result item keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_send) && $stable(rsp_tx_byte)
         && $stable(rsp_select) && $stable(rsp_data_valid) && $stable(rsp_data_byte)
         && $stable(rsp_data_index) && $stable(rsp_done_res) && $stable(rsp_success)
         && $stable(rsp_response_code) && $stable(rsp_rejected))
      else $error("stalled result item changed");

   // Every accepted item yields a result item in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item produced no result");

   // The finishing item releases the card and starts no exchange.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_select && !rsp_send && !rsp_data_valid)
      else $error("done result with select or exchange");

   // A block byte always comes with a further exchange under select.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid |-> rsp_select && rsp_send && !rsp_rejected)
      else $error("data byte without selected exchange");

endmodule

bind mmc_spi_block_read msbr_checker u_msbr_checker (.*);

// File: tb/mmc_spi_block_read_tb.sv
// Self-checking testbench for the card single-block read sequencer, with its own model.
module mmc_spi_block_read_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD = 20;
   localparam int LIMIT_CYCLES = 2_000_000;

   typedef struct packed {
      logic       send;
      logic [7:0] tx_byte;
      logic       select;
      logic       data_valid;
      logic [7:0] data_byte;
      logic [8:0] data_index;
      logic       done_res;
      logic       success;
      logic [7:0] response_code;
      logic       rejected;
   } spi_exchange_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [31:0] req_address;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_send;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_select;
   logic        rsp_data_valid;
   logic [7:0]  rsp_data_byte;
   logic [8:0]  rsp_data_index;
   logic        rsp_done_res;
   logic        rsp_success;
   logic [7:0]  rsp_response_code;
   logic        rsp_rejected;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [11:0] csr_data;

   msbr_pkg::phase_type seq_phase;
   logic [11:0] tries_used;
   logic [2:0]  cmd_pos;
   logic [31:0] block_addr;
   logic [31:0] next_base;
   logic        got_token;
   logic [7:0]  last_r1;
   logic [8:0]  byte_pos;
   logic [7:0]  resp_limit;
   logic [9:0]  token_limit;
   logic [11:0] release_limit;

   spi_exchange_type expected_exchanges[$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  jitter_on = 1'b0;

   mmc_spi_block_read dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_address(req_address),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_send(rsp_send),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_select(rsp_select),
      .rsp_data_valid(rsp_data_valid),
      .rsp_data_byte(rsp_data_byte),
      .rsp_data_index(rsp_data_index),
      .rsp_done_res(rsp_done_res),
      .rsp_success(rsp_success),
      .rsp_response_code(rsp_response_code),
      .rsp_rejected(rsp_rejected),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic logic [11:0] floor_one(logic [11:0] v);
      return (v == 12'd0) ? 12'd1 : v;
   endfunction

   function automatic spi_exchange_type next_exchange(msbr_pkg::kind_type kind,
                                                      logic [31:0] addr, logic [7:0] rx);
      spi_exchange_type r;
      logic busy;
      r = '0;
      busy = (seq_phase != msbr_pkg::PH_IDLE);
      if (kind == msbr_pkg::KIND_SET_BASE) begin
         next_base = addr;
      end else if (kind != msbr_pkg::KIND_RX_BYTE) begin
         if (busy) begin
            r.rejected = 1'b1;
         end else begin
            if (kind == msbr_pkg::KIND_READ_ADDR) begin
               block_addr = addr;
            end else begin
               block_addr = next_base;
               next_base = next_base + 32'(msbr_pkg::BLOCK_BYTES);
            end
            seq_phase = msbr_pkg::PH_CMD;
            cmd_pos = 3'd0;
            got_token = 1'b0;
            last_r1 = msbr_pkg::IDLE_BYTE;
            byte_pos = 9'd0;
            tries_used = 12'd0;
            r.send = 1'b1;
            r.tx_byte = msbr_pkg::CMD_READ_BLOCK;
         end
      end else if (!busy) begin
         r.rejected = 1'b1;
      end else begin
         r.send = 1'b1;
         r.tx_byte = msbr_pkg::IDLE_BYTE;
         case (seq_phase)
            msbr_pkg::PH_CMD: begin
               cmd_pos = cmd_pos + 3'd1;
               case (cmd_pos)
                  msbr_pkg::CMD_IDX_ADDR3: r.tx_byte = block_addr[31:24];
                  msbr_pkg::CMD_IDX_ADDR2: r.tx_byte = block_addr[23:16];
                  msbr_pkg::CMD_IDX_ADDR1: r.tx_byte = block_addr[15:8];
                  msbr_pkg::CMD_IDX_ADDR0: r.tx_byte = block_addr[7:0];
                  msbr_pkg::CMD_IDX_CRC: r.tx_byte = msbr_pkg::IDLE_BYTE;
                  default: begin
                     seq_phase = msbr_pkg::PH_RESP;
                     tries_used = 12'd1;
                  end
               endcase
            end
            msbr_pkg::PH_RESP: begin
               last_r1 = rx;
               if (rx == msbr_pkg::R1_READY) begin
                  seq_phase = msbr_pkg::PH_TOKEN;
                  tries_used = 12'd1;
               end else if (rx != msbr_pkg::R1_IDLE
                            && tries_used < floor_one(12'(resp_limit))) begin
                  tries_used++;
               end else begin
                  seq_phase = msbr_pkg::PH_TRAIL;
                  tries_used = 12'd1;
               end
            end
            msbr_pkg::PH_TOKEN: begin
               if (rx == msbr_pkg::START_TOKEN) begin
                  got_token = 1'b1;
                  seq_phase = msbr_pkg::PH_DATA;
                  byte_pos = 9'd0;
               end else if (tries_used < floor_one(12'(token_limit))) begin
                  tries_used++;
               end else begin
                  seq_phase = msbr_pkg::PH_TRAIL;
                  tries_used = 12'd1;
               end
            end
            msbr_pkg::PH_DATA: begin
               r.data_valid = 1'b1;
               r.data_byte = rx;
               r.data_index = byte_pos;
               if (int'(byte_pos) + 1 >= msbr_pkg::BLOCK_BYTES) begin
                  seq_phase = msbr_pkg::PH_TRAIL;
                  tries_used = 12'd1;
               end else begin
                  byte_pos++;
               end
            end
            msbr_pkg::PH_TRAIL: begin
               if (tries_used < msbr_pkg::TRAILER_BYTES) begin
                  tries_used++;
               end else begin
                  seq_phase = msbr_pkg::PH_RELEASE;
                  tries_used = 12'd1;
               end
            end
            default: begin
               if (rx != 8'h00 || tries_used >= floor_one(release_limit)) begin
                  seq_phase = msbr_pkg::PH_IDLE;
                  tries_used = 12'd0;
                  r.send = 1'b0;
                  r.tx_byte = 8'h00;
                  r.done_res = 1'b1;
                  r.success = got_token;
               end else begin
                  tries_used++;
               end
            end
         endcase
      end
      r.select = (seq_phase != msbr_pkg::PH_IDLE);
      r.response_code = last_r1;
      return r;
   endfunction

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int wait_near(logic [11:0] limit);
      int r;
      int lim;
      lim = int'(floor_one(limit));
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(0, 3);
      if (r < 9) return $urandom_range(lim - 1, lim);
      return -1;
   endfunction

   function automatic logic [11:0] random_limit();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 12'd0;
      if (r == 1) return 12'd1;
      return 12'($urandom_range(2, 40));
   endfunction

   task automatic report_mismatch(string what);
      $display("cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : check_results
      spi_exchange_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_exchanges.size() == 0) begin
            report_mismatch("result item arrived with nothing pending");
         end else begin
            want = expected_exchanges.pop_front();
            check_field("send", 32'(rsp_send), 32'(want.send));
            check_field("tx_byte", 32'(rsp_tx_byte), 32'(want.tx_byte));
            check_field("select", 32'(rsp_select), 32'(want.select));
            check_field("data_valid", 32'(rsp_data_valid), 32'(want.data_valid));
            check_field("data_byte", 32'(rsp_data_byte), 32'(want.data_byte));
            check_field("data_index", 32'(rsp_data_index), 32'(want.data_index));
            check_field("done_res", 32'(rsp_done_res), 32'(want.done_res));
            check_field("success", 32'(rsp_success), 32'(want.success));
            check_field("response_code", 32'(rsp_response_code),
                        32'(want.response_code));
            check_field("rejected", 32'(rsp_rejected), 32'(want.rejected));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0 && jitter_on && !reset)
         stall_left = idle_length();
      rsp_stall = (stall_left != 0);
      if (stall_left != 0)
         stall_left--;
   end

   task automatic send_item(msbr_pkg::kind_type kind, logic [31:0] addr, logic [7:0] rx);
      int gap;
      gap = jitter_on ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_address = addr;
      req_rx_byte = rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_exchanges.push_back(next_exchange(kind, addr, rx));
      items_sent++;
   endtask

   task automatic settle;
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_exchanges.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(msbr_pkg::csr_index_type idx, logic [11:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      case (idx)
         msbr_pkg::CSR_RESPONSE_TRIES: resp_limit = value[7:0];
         msbr_pkg::CSR_TOKEN_TRIES: token_limit = value[9:0];
         msbr_pkg::CSR_RELEASE_TRIES: release_limit = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic program_limits(logic [11:0] resp, logic [11:0] token, logic [11:0] rel);
      write_register(msbr_pkg::CSR_RESPONSE_TRIES, resp);
      write_register(msbr_pkg::CSR_TOKEN_TRIES, token);
      write_register(msbr_pkg::CSR_RELEASE_TRIES, rel);
   endtask

   // A wait of -1 means the awaited byte never comes.
   task automatic run_read(msbr_pkg::kind_type kind, logic [31:0] addr, int r1_wait,
                           logic [7:0] r1, int token_wait, int release_wait, int noise_pct);
      int count;
      msbr_pkg::phase_type seen;
      logic [7:0] rx;
      send_item(kind, addr, 8'($urandom));
      count = 0;
      seen = seq_phase;
      while (seq_phase != msbr_pkg::PH_IDLE) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_item(msbr_pkg::kind_type'($urandom_range(0, 2)), $urandom, 8'($urandom));
            continue;
         end
         if (seq_phase != seen) begin
            count = 0;
            seen = seq_phase;
         end
         case (seq_phase)
            msbr_pkg::PH_RESP:
               if (count == r1_wait) rx = r1;
               else if ($urandom_range(0, 3) != 0) rx = msbr_pkg::IDLE_BYTE;
               else rx = 8'($urandom_range(2, 255));
            msbr_pkg::PH_TOKEN:
               if (count == token_wait) rx = msbr_pkg::START_TOKEN;
               else if ($urandom_range(0, 3) != 0) rx = msbr_pkg::IDLE_BYTE;
               else rx = 8'($urandom_range(0, 253));
            msbr_pkg::PH_RELEASE:
               rx = (count == release_wait) ? 8'($urandom_range(1, 255)) : 8'h00;
            default: rx = 8'($urandom);
         endcase
         send_item(msbr_pkg::KIND_RX_BYTE, $urandom, rx);
         count++;
      end
   endtask

   task automatic test_reset_defaults;
      jitter_on = 1'b0;
      send_item(msbr_pkg::KIND_RX_BYTE, 32'h0000_0000, 8'hA5);
      run_read(msbr_pkg::KIND_READ_BASE, $urandom, 2, msbr_pkg::R1_READY, 3, 1, 0);
      run_read(msbr_pkg::KIND_READ_ADDR, 32'hFFFF_FFFF, 0, msbr_pkg::R1_IDLE, 0, 0, 20);
      run_read(msbr_pkg::KIND_READ_ADDR, 32'h8000_0001, -1, msbr_pkg::R1_READY, 0, 0, 0);
      run_read(msbr_pkg::KIND_READ_ADDR, 32'h0000_0000, 0, msbr_pkg::R1_IDLE, 0, 3, 5);
   endtask

   task automatic test_sequential_base;
      jitter_on = 1'b1;
      send_item(msbr_pkg::KIND_SET_BASE, 32'hFFFF_FE00, 8'h00);
      run_read(msbr_pkg::KIND_READ_BASE, 32'h1234_5678, 0, msbr_pkg::R1_IDLE, 0, 0, 0);
      run_read(msbr_pkg::KIND_READ_BASE, 32'h0000_0000, 1, msbr_pkg::R1_IDLE, 0, 2, 30);
      run_read(msbr_pkg::KIND_READ_BASE, $urandom, 0, msbr_pkg::R1_READY, 0, 0, 3);
   endtask

   task automatic test_register_extremes;
      jitter_on = 1'b1;
      settle;
      program_limits(12'd1, 12'd1, 12'd1);
      run_read(msbr_pkg::KIND_READ_ADDR, $urandom, -1, msbr_pkg::R1_READY, 0, 0, 0);
      run_read(msbr_pkg::KIND_READ_ADDR, $urandom, 0, msbr_pkg::R1_READY, -1, -1, 0);
      settle;
      program_limits(12'd0, 12'd0, 12'd0);
      run_read(msbr_pkg::KIND_READ_ADDR, $urandom, -1, msbr_pkg::R1_READY, 0, 0, 0);
      run_read(msbr_pkg::KIND_READ_ADDR, $urandom, 0, msbr_pkg::R1_READY, -1, -1, 0);
      settle;
      write_register(msbr_pkg::CSR_UNUSED, 12'hFFF);
      program_limits(12'hFFF, 12'hFFF, 12'hFFF);
      run_read(msbr_pkg::KIND_READ_ADDR, $urandom, 6, msbr_pkg::R1_IDLE, 0, 7, 2);
      settle;
      program_limits(12'hF05, 12'hC07, 12'd9);
      run_read(msbr_pkg::KIND_READ_ADDR, $urandom, 4, msbr_pkg::R1_READY, -1, 8, 0);
      run_read(msbr_pkg::KIND_READ_ADDR, $urandom, 5, msbr_pkg::R1_READY, 0, -1, 0);
   endtask

   task automatic test_random_traffic;
      int round;
      int target;
      int pick;
      logic [7:0] r1;
      for (round = 0; round < 3; round++) begin
         settle;
         write_register(msbr_pkg::CSR_RESPONSE_TRIES,
                        {4'($urandom_range(0, 15)), 8'(random_limit())});
         write_register(msbr_pkg::CSR_TOKEN_TRIES,
                        {2'($urandom_range(0, 3)), 10'(random_limit())});
         write_register(msbr_pkg::CSR_RELEASE_TRIES, random_limit());
         if ($urandom_range(0, 3) == 0)
            write_register(msbr_pkg::CSR_UNUSED, 12'($urandom));
         jitter_on = (round % 3) != 1;
         target = items_sent + 30;
         while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               send_item(msbr_pkg::KIND_RX_BYTE, $urandom, 8'($urandom));
            end else if (pick < 10) begin
               send_item(msbr_pkg::KIND_SET_BASE, $urandom, 8'($urandom));
            end else begin
               r1 = ($urandom_range(0, 3) == 0) ? msbr_pkg::R1_READY : msbr_pkg::R1_IDLE;
               run_read(msbr_pkg::kind_type'($urandom_range(0, 1)), $urandom,
                        wait_near(12'(resp_limit)), r1, -1, wait_near(release_limit),
                        6 * $urandom_range(0, 1));
            end
         end
      end
   endtask

   initial begin
      seq_phase = msbr_pkg::PH_IDLE;
      tries_used = 12'd0;
      cmd_pos = 3'd0;
      block_addr = 32'd0;
      next_base = msbr_pkg::START_BASE;
      got_token = 1'b0;
      last_r1 = msbr_pkg::IDLE_BYTE;
      byte_pos = 9'd0;
      resp_limit = msbr_pkg::RESPONSE_TRIES_RESET;
      token_limit = msbr_pkg::TOKEN_TRIES_RESET;
      release_limit = msbr_pkg::RELEASE_TRIES_RESET;
      req_valid = 1'b0;
      req_kind = msbr_pkg::KIND_RX_BYTE;
      req_address = 32'd0;
      req_rx_byte = 8'd0;
      csr_write = 1'b0;
      csr_index = msbr_pkg::CSR_RESPONSE_TRIES;
      csr_data = 12'd0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults;
      test_sequential_base;
      test_register_extremes;
      test_random_traffic;
      settle;
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
rtl/msbr_pkg.sv
rtl/mmc_spi_block_read.sv
rtl/msbr_checker.sv
tb/mmc_spi_block_read_tb.sv
